// ===== sv/gfm_pkg.sv =====
// ----------------------------------------------------------------------------
// Feature map package
// Types, codes, sizes and the quarter-wave sine table that the feature map
// block shares between its modules.
// ----------------------------------------------------------------------------
package gfm_pkg;

    // Table sizes.
    localparam int CAPACITY         = 64;
    localparam int SINE_TABLE_DEPTH = 256;

    // Derived widths.
    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int IDX_W = $clog2(CAPACITY);
    localparam int TI_W  = $clog2(SINE_TABLE_DEPTH + 1);

    // Pi / 2 in Q30.
    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

    // Request codes.
    typedef enum logic [1:0] {
        REQ_POINT     = 2'd0,
        REQ_TICK      = 2'd1,
        REQ_FRAME_END = 2'd2,
        REQ_RESERVED  = 2'd3
    } t_req;

    // Result status codes.
    typedef enum logic [2:0] {
        ST_MATCHED    = 3'd0,
        ST_INSERTED   = 3'd1,
        ST_DROPPED    = 3'd2,
        ST_TICK_DONE  = 3'd3,
        ST_PURGE_DONE = 3'd4
    } t_status;

    // Configuration register indexes.
    typedef enum logic [1:0] {
        CFG_OFS_X   = 2'd0,
        CFG_OFS_Y   = 2'd1,
        CFG_GATE    = 2'd2,
        CFG_MAX_AGE = 2'd3
    } t_cfg_idx;

    // Sequencer states.
    typedef enum logic [2:0] {
        S_IDLE,
        S_XFORM,
        S_SCAN,
        S_FINISH,
        S_INSERT
    } t_fsm;

    // One input beat.
    typedef struct packed {
        logic [1:0]         req_type;
        logic signed [31:0] point_x;
        logic signed [31:0] point_y;
        logic signed [31:0] robot_x;
        logic signed [31:0] robot_y;
        logic [15:0]        robot_yaw;
    } t_in_item;

    // One result beat.
    typedef struct packed {
        logic [2:0]         status;
        logic [6:0]         match_count;
        logic [6:0]         entry_count;
        logic signed [31:0] global_x;
        logic signed [31:0] global_y;
    } t_out_item;

    // One map entry as held by a cell.
    typedef struct packed {
        logic        valid;
        logic [31:0] pos_x;
        logic [31:0] pos_y;
        logic [31:0] birth;
    } t_entry;

    // Per-cell load controls.
    typedef struct packed {
        logic shift;
        logic upd;
        logic ins;
    } t_cell_ctl;

    // Verdict on the entry at the tail of the chain.
    typedef struct packed {
        logic vld;
        logic match;
        logic purge;
    } t_dec;

    typedef logic [16:0] t_sine_tab [0:SINE_TABLE_DEPTH];

    // Quarter-wave sine in Q16, built from a Q30 Taylor series.
    function automatic t_sine_tab build_sine_tab();
        t_sine_tab   tab;
        logic [63:0] th;
        logic [63:0] th2;
        logic [63:0] term;
        logic [63:0] sum;
        for (int i = 0; i <= SINE_TABLE_DEPTH; i++) begin
            th   = (HALF_PI_Q30 * 64'(i) + 64'(SINE_TABLE_DEPTH / 2))
                   / 64'(SINE_TABLE_DEPTH);
            th2  = (th * th) >> 30;
            term = th;
            sum  = th;
            for (int k = 1; k <= 8; k++) begin
                term = ((term * th2) >> 30) / 64'((2 * k) * (2 * k + 1));
                if (k[0]) begin
                    sum = sum - term;
                end else begin
                    sum = sum + term;
                end
            end
            tab[i] = 17'((sum + 64'd8192) >> 14);
        end
        return tab;
    endfunction

    localparam t_sine_tab SINE_TAB = build_sine_tab();

endpackage

// ===== sv/gfm_cell.sv =====
// ----------------------------------------------------------------------------
// Feature map cell
// Holds one map entry and passes it to its neighbor while the chain rotates.
// ----------------------------------------------------------------------------
module gfm_cell (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  gfm_pkg::t_cell_ctl i_ctl,
    input  gfm_pkg::t_entry   i_next,
    input  gfm_pkg::t_entry   i_upd_data,
    input  gfm_pkg::t_entry   i_ins_data,
    output gfm_pkg::t_entry   o_entry
);
    import gfm_pkg::*;

    t_entry r_entry;
    t_entry n_entry;

    // Insertion wins over an in-place update, which wins over the rotation.
    always_comb begin
        n_entry = r_entry;
        if (i_ctl.ins) begin
            n_entry = i_ins_data;
        end else if (i_ctl.upd) begin
            n_entry = i_upd_data;
        end else if (i_ctl.shift) begin
            n_entry = i_next;
        end
    end

    // The valid bit is cleared by reset; the payload is not.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_entry.valid <= 1'b0;
        end else begin
            r_entry.valid <= n_entry.valid;
        end
        r_entry.pos_x <= n_entry.pos_x;
        r_entry.pos_y <= n_entry.pos_y;
        r_entry.birth <= n_entry.birth;
    end

    assign o_entry = r_entry;

endmodule

// ===== sv/gfm_xform.sv =====
// ----------------------------------------------------------------------------
// Feature map point transform
// Four-stage pipeline: sensor offset and sine lookup, products, sums, and
// rounding plus robot translation.
// ----------------------------------------------------------------------------
module gfm_xform (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  gfm_pkg::t_in_item  i_item,
    input  logic [31:0]        i_ofs_x,
    input  logic [31:0]        i_ofs_y,
    output logic               o_valid,
    output logic signed [31:0] o_gx,
    output logic signed [31:0] o_gy
);
    import gfm_pkg::*;

    localparam int PW = 14 + TI_W + 1;

    // Signed Q16 sine of a 16-bit angle from the quarter-wave table.
    function automatic logic signed [17:0] sine_q16(input logic [15:0] a);
        logic [PW-1:0]      p;
        logic [TI_W-1:0]    idx;
        logic signed [17:0] v;
        p   = PW'(a[13:0]) * PW'(SINE_TABLE_DEPTH) + PW'(8192);
        idx = TI_W'(p >> 14);
        if (idx > TI_W'(SINE_TABLE_DEPTH)) begin
            idx = TI_W'(SINE_TABLE_DEPTH);
        end
        if (a[14]) begin
            v = {1'b0, SINE_TAB[TI_W'(SINE_TABLE_DEPTH) - idx]};
        end else begin
            v = {1'b0, SINE_TAB[idx]};
        end
        if (a[15]) begin
            v = -v;
        end
        return v;
    endfunction

    logic               r_v1, r_v2, r_v3, r_v4;
    logic signed [32:0] r_sx, r_sy;
    logic signed [17:0] r_sin, r_cos;
    logic signed [31:0] r_rx1, r_ry1, r_rx2, r_ry2, r_rx3, r_ry3;
    logic signed [50:0] r_xc, r_ys, r_xs, r_yc;
    logic signed [51:0] r_vx, r_vy;
    logic signed [31:0] r_gx, r_gy;
    logic signed [51:0] w_tx, w_ty;

    // Stage valid flags.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
        end
    end

    // Rounding to Q16.16 is an add of one half and a floor.
    assign w_tx = r_vx + 52'sd32768;
    assign w_ty = r_vy + 52'sd32768;

    // Datapath stages.
    always_ff @(posedge i_clk) begin
        r_sx  <= {i_item.point_x[31], i_item.point_x} + {i_ofs_x[31], i_ofs_x};
        r_sy  <= {i_item.point_y[31], i_item.point_y} + {i_ofs_y[31], i_ofs_y};
        r_sin <= sine_q16(i_item.robot_yaw);
        r_cos <= sine_q16(i_item.robot_yaw + 16'd16384);
        r_rx1 <= i_item.robot_x;
        r_ry1 <= i_item.robot_y;

        r_xc  <= r_sx * r_cos;
        r_ys  <= r_sy * r_sin;
        r_xs  <= r_sx * r_sin;
        r_yc  <= r_sy * r_cos;
        r_rx2 <= r_rx1;
        r_ry2 <= r_ry1;

        r_vx  <= 52'(r_xc) - 52'(r_ys);
        r_vy  <= 52'(r_xs) + 52'(r_yc);
        r_rx3 <= r_rx2;
        r_ry3 <= r_ry2;

        r_gx  <= r_rx3 + w_tx[47:16];
        r_gy  <= r_ry3 + w_ty[47:16];
    end

    assign o_valid = r_v4;
    assign o_gx    = r_gx;
    assign o_gy    = r_gy;

endmodule

// ===== sv/gfm_judge.sv =====
// ----------------------------------------------------------------------------
// Feature map entry judge
// Squares the distance of the entry leaving the head of the chain, registers the
// squares, and in the next cycle decides match or purge for the same entry at the tail.
// ----------------------------------------------------------------------------
module gfm_judge (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_calc,
    input  gfm_pkg::t_entry    i_head,
    input  gfm_pkg::t_entry    i_tail,
    input  logic               i_purge_mode,
    input  logic               i_bulk,
    input  logic [31:0]        i_px,
    input  logic [31:0]        i_py,
    input  logic [62:0]        i_gate,
    input  logic [31:0]        i_tick,
    input  logic [31:0]        i_max_age,
    output gfm_pkg::t_dec      o_dec
);
    import gfm_pkg::*;

    logic               r_vld;
    logic [63:0]        r_dx2, r_dy2;
    logic signed [32:0] w_dx, w_dy;
    logic signed [65:0] w_dx2, w_dy2;
    logic [64:0]        w_sum;
    logic [63:0]        w_gate;
    logic [31:0]        w_age;

    // Distance squares of the head entry.
    assign w_dx  = {i_head.pos_x[31], i_head.pos_x} - {i_px[31], i_px};
    assign w_dy  = {i_head.pos_y[31], i_head.pos_y} - {i_py[31], i_py};
    assign w_dx2 = w_dx * w_dx;
    assign w_dy2 = w_dy * w_dy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else begin
            r_vld <= i_calc;
        end
    end

    always_ff @(posedge i_clk) begin
        r_dx2 <= w_dx2[63:0];
        r_dy2 <= w_dy2[63:0];
    end

    // Verdict for the tail entry.
    assign w_sum  = {1'b0, r_dx2} + {1'b0, r_dy2};
    assign w_gate = {1'b0, i_gate};
    assign w_age  = i_tick - i_tail.birth;

    always_comb begin
        o_dec.vld   = r_vld;
        o_dec.match = r_vld && !i_purge_mode && !i_bulk && i_tail.valid
                      && (r_dx2 < w_gate) && (r_dy2 < w_gate)
                      && (w_sum < {1'b0, w_gate});
        o_dec.purge = r_vld && i_purge_mode && i_tail.valid && (w_age > i_max_age);
    end

endmodule

// ===== sv/gated_feature_map_update_top.sv =====
// ----------------------------------------------------------------------------
// Gated feature map update, top level
// Tick and reserved requests are answered straight from idle; frame end and
// point requests each take one rotation of the cell chain through the single
// distance judge, a point after the transform pipeline. One request at a time.
// Reset clears all entries' valid bits, the tick, the frame flags and the
// configuration to defaults at once. Results are strobed and cannot stall.
// ----------------------------------------------------------------------------
module gated_feature_map_update_top (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    output logic               o_busy,
    input  gfm_pkg::t_in_item  i_item,
    output logic               o_strobe,
    output gfm_pkg::t_out_item o_result,
    input  logic               i_cfg_we,
    input  logic [1:0]         i_cfg_idx,
    input  logic [62:0]        i_cfg_data
);
    import gfm_pkg::*;

    // Zero-extend or truncate a count to the seven-bit result field.
    function automatic logic [6:0] to7(input logic [CNT_W-1:0] v);
        logic [CNT_W+6:0] t;
        t = {7'b0, v};
        return t[6:0];
    endfunction

    t_fsm r_state, n_state;

    logic [31:0]      r_ofs_x, r_ofs_y, r_max_age, r_tick;
    logic [62:0]      r_gate;
    logic             r_frame_open, r_bulk, r_purge_mode;
    logic [CNT_W-1:0] r_count, n_count, r_match_cnt;
    logic             r_free_found;
    logic [IDX_W-1:0] r_free_idx, r_tail_idx, r_cnt;
    logic [31:0]      r_gx, r_gy;
    logic             r_strobe;
    t_out_item        r_out, n_out;

    logic             w_accept, w_scan, w_finish, w_insert, w_emit, w_do_ins;
    logic             xf_valid;
    logic [31:0]      xf_gx, xf_gy;
    t_dec             w_dec;
    t_entry           w_cell [CAPACITY];
    t_entry           w_mod_tail, w_ins_data;

    assign w_accept = i_start && (r_state == S_IDLE);
    assign o_busy   = (r_state != S_IDLE);

    // Configuration writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ofs_x   <= '0;
            r_ofs_y   <= '0;
            r_gate    <= 63'd1073741824;
            r_max_age <= 32'd3000;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_OFS_X:   r_ofs_x   <= i_cfg_data[31:0];
                CFG_OFS_Y:   r_ofs_y   <= i_cfg_data[31:0];
                CFG_GATE:    r_gate    <= i_cfg_data;
                CFG_MAX_AGE: r_max_age <= i_cfg_data[31:0];
                default:     r_gate    <= r_gate;
            endcase
        end
    end

    // Point transform pipeline.
    gfm_xform u_xform (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_accept && (t_req'(i_item.req_type) == REQ_POINT)),
        .i_item  (i_item),
        .i_ofs_x (r_ofs_x),
        .i_ofs_y (r_ofs_y),
        .o_valid (xf_valid),
        .o_gx    (xf_gx),
        .o_gy    (xf_gy)
    );

    // Distance and age judge between the head and the tail of the chain.
    gfm_judge u_judge (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_calc       (w_scan),
        .i_head       (w_cell[0]),
        .i_tail       (w_cell[CAPACITY-1]),
        .i_purge_mode (r_purge_mode),
        .i_bulk       (r_bulk),
        .i_px         (r_gx),
        .i_py         (r_gy),
        .i_gate       (r_gate),
        .i_tick       (r_tick),
        .i_max_age    (r_max_age),
        .o_dec        (w_dec)
    );

    // Tail entry after the verdict.
    always_comb begin
        w_mod_tail = w_cell[CAPACITY-1];
        if (w_dec.match) begin
            w_mod_tail.pos_x = r_gx;
            w_mod_tail.pos_y = r_gy;
        end
        if (w_dec.purge) begin
            w_mod_tail.valid = 1'b0;
        end
    end

    assign w_do_ins   = (r_match_cnt == '0) && r_free_found;
    assign w_ins_data = '{valid: 1'b1, pos_x: r_gx, pos_y: r_gy, birth: r_tick};

    // Chain of cells: entries move toward cell 0, the head wraps to the tail.
    for (genvar k = 0; k < CAPACITY; k++) begin : g_cell
        t_cell_ctl w_ctl;
        t_entry    w_next;
        always_comb begin
            w_ctl.shift = w_scan;
            w_ctl.upd   = w_finish && (k == CAPACITY - 1);
            w_ctl.ins   = w_insert && w_do_ins && (r_free_idx == IDX_W'(k));
            if (k == CAPACITY - 1) begin
                w_next = w_cell[0];
            end else if (k == CAPACITY - 2) begin
                w_next = w_mod_tail;
            end else begin
                w_next = w_cell[(k + 1) % CAPACITY];
            end
        end
        gfm_cell u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_ctl      (w_ctl),
            .i_next     (w_next),
            .i_upd_data (w_mod_tail),
            .i_ins_data (w_ins_data),
            .o_entry    (w_cell[k])
        );
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_accept && (t_req'(i_item.req_type) == REQ_POINT)) begin
                    n_state = S_XFORM;
                end else if (w_accept
                             && (t_req'(i_item.req_type) == REQ_FRAME_END)) begin
                    n_state = S_SCAN;
                end
            end
            S_XFORM: begin
                if (xf_valid) begin
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                if (r_cnt == IDX_W'(CAPACITY - 1)) begin
                    n_state = S_FINISH;
                end
            end
            S_FINISH: begin
                n_state = r_purge_mode ? S_IDLE : S_INSERT;
            end
            S_INSERT: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State outputs.
    always_comb begin
        w_scan   = 1'b0;
        w_finish = 1'b0;
        w_insert = 1'b0;
        w_emit   = 1'b0;
        case (r_state)
            S_IDLE: begin
                w_emit = w_accept && (t_req'(i_item.req_type) != REQ_POINT)
                         && (t_req'(i_item.req_type) != REQ_FRAME_END);
            end
            S_XFORM: begin
                w_emit = 1'b0;
            end
            S_SCAN: begin
                w_scan = 1'b1;
            end
            S_FINISH: begin
                w_finish = 1'b1;
                w_emit   = r_purge_mode;
            end
            S_INSERT: begin
                w_insert = 1'b1;
                w_emit   = 1'b1;
            end
            default: begin
                w_emit = 1'b0;
            end
        endcase
    end

    // Valid entry count.
    always_comb begin
        n_count = r_count;
        if (w_dec.purge) begin
            n_count = r_count - 1'b1;
        end else if (w_insert && w_do_ins) begin
            n_count = r_count + 1'b1;
        end
    end

    // Result beat.
    always_comb begin
        n_out.status      = ST_TICK_DONE;
        n_out.match_count = '0;
        n_out.entry_count = to7(n_count);
        n_out.global_x    = '0;
        n_out.global_y    = '0;
        if (w_insert) begin
            n_out.match_count = to7(r_match_cnt);
            n_out.global_x    = r_gx;
            n_out.global_y    = r_gy;
            if (r_match_cnt != '0) begin
                n_out.status = ST_MATCHED;
            end else if (r_free_found) begin
                n_out.status = ST_INSERTED;
            end else begin
                n_out.status = ST_DROPPED;
            end
        end else if (w_finish) begin
            n_out.status = ST_PURGE_DONE;
        end
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_tick       <= '0;
            r_frame_open <= 1'b0;
            r_bulk       <= 1'b0;
            r_purge_mode <= 1'b0;
            r_count      <= '0;
            r_match_cnt  <= '0;
            r_free_found <= 1'b0;
            r_free_idx   <= '0;
            r_tail_idx   <= '0;
            r_cnt        <= '0;
            r_strobe     <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_strobe <= w_emit;
            if (w_accept) begin
                r_cnt        <= '0;
                r_match_cnt  <= '0;
                r_free_found <= 1'b0;
                r_purge_mode <= (t_req'(i_item.req_type) == REQ_FRAME_END);
                if (t_req'(i_item.req_type) == REQ_TICK) begin
                    r_tick <= r_tick + 32'd1;
                end
                if ((t_req'(i_item.req_type) == REQ_POINT) && !r_frame_open) begin
                    r_frame_open <= 1'b1;
                    r_bulk       <= (r_count == '0);
                end
            end
            if (w_scan) begin
                r_cnt      <= r_cnt + 1'b1;
                r_tail_idx <= r_cnt;
            end
            // Bookkeeping for the entry judged at the tail.
            if (w_dec.vld) begin
                if (w_dec.match) begin
                    r_match_cnt <= r_match_cnt + 1'b1;
                end
                if (!w_cell[CAPACITY-1].valid && !r_free_found) begin
                    r_free_found <= 1'b1;
                    r_free_idx   <= r_tail_idx;
                end
            end
            if (w_finish && r_purge_mode) begin
                r_frame_open <= 1'b0;
                r_bulk       <= 1'b0;
            end
        end
    end

    // Point and result payload.
    always_ff @(posedge i_clk) begin
        if (xf_valid) begin
            r_gx <= xf_gx;
            r_gy <= xf_gy;
        end
        if (w_emit) begin
            r_out <= n_out;
        end
    end

    assign o_strobe = r_strobe;
    assign o_result = r_out;

endmodule
